FILE: rtl/core/lgs_pkg.sv
// lgs_pkg: shared codes and constants for the life grid step unit
// no dependencies; imported by life_grid_step_unit

package lgs_pkg;

    // default grid storage size
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0]  CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET   = 7'd64;

    // request codes
    localparam int REQ_W = 2;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STEP  = 2'd2;

    // item field widths
    localparam int COL_W    = 6;
    localparam int ROW_W    = 6;
    localparam int VAL_W    = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;

    // neighbor count rule
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] NBR_BIRTH = 4'd3;
    localparam logic [CNT_W-1:0] NBR_KEEP  = 4'd2;

endpackage

FILE: rtl/core/lgs_ram.sv
// lgs_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies; used by life_grid_step_unit for the cell planes

module lgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/life_grid_step_unit.sv
// life_grid_step_unit: toroidal game of life engine with two cell planes
// depends on lgs_pkg and lgs_ram

// The grid lives in a row-wide ram holding two planes of MAX_HEIGHT rows of
// MAX_WIDTH cells; after reset a clearing pass writes zero to all
// 2*MAX_HEIGHT rows, one row a cycle, during which no item is taken
// (configuration writes are). One item is handled at a time. A cell write or
// read loads the row, then writes it back or picks the cell, then posts the
// result. A generation steps one shared neighbor counter over the cells, one
// cell a cycle, behind a row-per-cycle ram port: an active row takes three
// row loads, the cells and one row write, an unused row only a row write of
// zeros. Result items wait in an output register until taken.

module life_grid_step_unit #(
    parameter int MAX_WIDTH  = lgs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lgs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: cell_column[5:0], cell_row[11:6], write_value[19:12], zero pad
    input  logic [lgs_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [lgs_pkg::REQ_W-1:0]       s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: read_value[0], step_done[1], zero pad
    output logic [lgs_pkg::M_DATA_W-1:0]    m_axis_tdata,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lgs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import lgs_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = 2 * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL_RD,
        ST_CELL_OP,
        ST_GEN_ROW,
        ST_GEN_LD1,
        ST_GEN_LD2,
        ST_GEN_LD3,
        ST_GEN_CELL,
        ST_GEN_WR,
        ST_POST
    } t_state;

    t_state                 r_state;
    logic [CFG_DATA_W-1:0]  r_cfg_width;
    logic [CFG_DATA_W-1:0]  r_cfg_height;
    logic                   r_plane;
    logic [AW-1:0]          r_clr_addr;
    logic [REQ_W-1:0]       r_req;
    logic [COL_W-1:0]       r_col;
    logic [ROW_W-1:0]       r_row;
    logic                   r_alive;
    logic [YW-1:0]          r_gen_row;
    logic [XW-1:0]          r_gen_col;
    logic [MAX_WIDTH-1:0]   r_up;
    logic [MAX_WIDTH-1:0]   r_mid;
    logic [MAX_WIDTH-1:0]   r_dn;
    logic [MAX_WIDTH-1:0]   r_out;
    logic                   r_res_read;
    logic                   r_res_done;
    logic                   r_m_valid;
    logic                   r_m_read;
    logic                   r_m_done;

    logic [WW-1:0]          w_eff;
    logic [HW-1:0]          h_eff;
    logic [COL_W-1:0]       in_col;
    logic [ROW_W-1:0]       in_row;
    logic [VAL_W-1:0]       in_val;
    logic                   in_area;
    logic                   s_accept;
    logic [YW-1:0]          row_above;
    logic [YW-1:0]          row_below;
    logic                   row_active;
    logic                   row_last;
    logic [XW-1:0]          col_left;
    logic [XW-1:0]          col_right;
    logic                   col_last;
    logic [CNT_W-1:0]       nbr_cnt;
    logic                   cell_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [MAX_WIDTH-1:0]   ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [MAX_WIDTH-1:0]   ram_rdata;
    logic [MAX_WIDTH-1:0]   n_row_mod;

    // ram row address of a row in a plane
    function automatic logic [AW-1:0] row_addr(input logic plane, input logic [YW-1:0] row);
        logic [AW-1:0] base;
        base = plane ? AW'(MAX_HEIGHT) : '0;
        return base + AW'(row);
    endfunction

    // request fields
    assign in_col = s_axis_tdata[COL_W-1:0];
    assign in_row = s_axis_tdata[COL_W+ROW_W-1:COL_W];
    assign in_val = s_axis_tdata[COL_W+ROW_W+VAL_W-1:COL_W+ROW_W];

    // grid size in use, zero counts as one, large values saturate
    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_cfg_height) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_cfg_height);
        end
    end

    assign in_area  = (32'(in_col) < 32'(w_eff)) && (32'(in_row) < 32'(h_eff));
    assign s_accept = s_axis_tvalid && s_axis_tready;

    // wrapped neighbor rows of the current generation row
    assign row_active = 32'(r_gen_row) < 32'(h_eff);
    assign row_last   = 32'(r_gen_row) == 32'(h_eff) - 32'd1;
    assign row_above  = (r_gen_row == '0) ? YW'(h_eff - HW'(1)) : r_gen_row - YW'(1);
    assign row_below  = row_last ? '0 : r_gen_row + YW'(1);

    // wrapped neighbor columns of the current cell
    assign col_last  = 32'(r_gen_col) == 32'(w_eff) - 32'd1;
    assign col_left  = (r_gen_col == '0) ? XW'(w_eff - WW'(1)) : r_gen_col - XW'(1);
    assign col_right = col_last ? '0 : r_gen_col + XW'(1);

    // shared neighbor counter and rule
    assign nbr_cnt = CNT_W'(r_up[col_left])  + CNT_W'(r_up[r_gen_col]) + CNT_W'(r_up[col_right])
                   + CNT_W'(r_mid[col_left])                           + CNT_W'(r_mid[col_right])
                   + CNT_W'(r_dn[col_left])  + CNT_W'(r_dn[r_gen_col]) + CNT_W'(r_dn[col_right]);
    assign cell_next = (nbr_cnt == NBR_BIRTH) || ((nbr_cnt == NBR_KEEP) && r_mid[r_gen_col]);

    // row with the addressed cell replaced, for a cell write
    always_comb begin
        n_row_mod = ram_rdata;
        n_row_mod[XW'(r_col)] = r_alive;
    end

    // ram port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
            end
            ST_CELL_RD: begin
                ram_raddr = row_addr(r_plane, YW'(r_row));
            end
            ST_CELL_OP: begin
                ram_we    = (r_req == REQ_WRITE);
                ram_waddr = row_addr(r_plane, YW'(r_row));
                ram_wdata = n_row_mod;
            end
            ST_GEN_ROW: begin
                ram_raddr = row_addr(r_plane, row_above);
            end
            ST_GEN_LD1: begin
                ram_raddr = row_addr(r_plane, r_gen_row);
            end
            ST_GEN_LD2: begin
                ram_raddr = row_addr(r_plane, row_below);
            end
            ST_GEN_WR: begin
                ram_we    = 1'b1;
                ram_waddr = row_addr(~r_plane, r_gen_row);
                ram_wdata = r_out;
            end
            default: begin
            end
        endcase
    end

    lgs_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (DEPTH)
    ) u_planes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer, registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_plane      <= 1'b0;
            r_cfg_width  <= CFG_DIM_RESET;
            r_cfg_height <= CFG_DIM_RESET;
            r_m_valid    <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GRID_WIDTH:  r_cfg_width  <= i_cfg_data;
                    CFG_GRID_HEIGHT: r_cfg_height <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // result taken
            if (m_axis_tready && (r_state != ST_POST)) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_accept) begin
                        r_req      <= s_axis_tuser;
                        r_col      <= in_col;
                        r_row      <= in_row;
                        r_alive    <= |in_val;
                        r_res_read <= 1'b0;
                        r_res_done <= 1'b0;
                        r_gen_row  <= '0;
                        if (s_axis_tuser == REQ_STEP) begin
                            r_state <= ST_GEN_ROW;
                        end else if (((s_axis_tuser == REQ_WRITE) || (s_axis_tuser == REQ_READ))
                                     && in_area) begin
                            r_state <= ST_CELL_RD;
                        end else begin
                            r_state <= ST_POST;
                        end
                    end
                end
                ST_CELL_RD: begin
                    r_state <= ST_CELL_OP;
                end
                ST_CELL_OP: begin
                    if (r_req == REQ_READ) begin
                        r_res_read <= ram_rdata[XW'(r_col)];
                    end
                    r_state <= ST_POST;
                end
                ST_GEN_ROW: begin
                    r_out <= '0;
                    if (row_active) begin
                        r_state <= ST_GEN_LD1;
                    end else begin
                        r_state <= ST_GEN_WR;
                    end
                end
                ST_GEN_LD1: begin
                    r_up    <= ram_rdata;
                    r_state <= ST_GEN_LD2;
                end
                ST_GEN_LD2: begin
                    r_mid   <= ram_rdata;
                    r_state <= ST_GEN_LD3;
                end
                ST_GEN_LD3: begin
                    r_dn      <= ram_rdata;
                    r_gen_col <= '0;
                    r_state   <= ST_GEN_CELL;
                end
                ST_GEN_CELL: begin
                    r_out[r_gen_col] <= cell_next;
                    if (col_last) begin
                        r_state <= ST_GEN_WR;
                    end else begin
                        r_gen_col <= r_gen_col + XW'(1);
                    end
                end
                ST_GEN_WR: begin
                    if (r_gen_row == YW'(MAX_HEIGHT - 1)) begin
                        r_plane    <= ~r_plane;
                        r_res_done <= 1'b1;
                        r_state    <= ST_POST;
                    end else begin
                        r_gen_row <= r_gen_row + YW'(1);
                        r_state   <= ST_GEN_ROW;
                    end
                end
                ST_POST: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_read  <= r_res_read;
                        r_m_done  <= r_res_done;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // port outputs
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(M_DATA_W - 2)'(0), r_m_done, r_m_read};
    assign o_cfg_ready   = 1'b1;

endmodule

FILE: tb/sv/tb_life_grid_step_unit.sv
`timescale 1ns / 1ps
// tb_life_grid_step_unit: self-checking bench for the toroidal life grid step unit
// depends on lgs_pkg and life_grid_step_unit; drives cell writes, reads and generations
// against a bit-level grid predictor, with random stalls on both streams

module tb_life_grid_step_unit;
    import lgs_pkg::*;

    localparam int GRID_MAX_W = DEF_MAX_WIDTH;
    localparam int GRID_MAX_H = DEF_MAX_HEIGHT;
    localparam logic [REQ_W-1:0]     REQ_UNUSED     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int QUIET_LIMIT = 20000;
    localparam int N_PHASES    = 14;
    localparam int N_FIXED     = 12;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [VAL_W-1:0] val;
    } grid_req_t;

    typedef struct packed {
        logic read_value;
        logic step_done;
    } grid_resp_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_DATA_W-1:0]    s_axis_tdata  = '0;
    logic [REQ_W-1:0]       s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    // predictor state: two planes indexed [plane][row][column]
    bit                     grid_bits [2][GRID_MAX_H][GRID_MAX_W];
    bit                     live_plane = 1'b0;
    logic [CFG_DATA_W-1:0]  width_reg  = CFG_DIM_RESET;
    logic [CFG_DATA_W-1:0]  height_reg = CFG_DIM_RESET;

    grid_req_t      request_q [$];
    grid_resp_t     expected_resp_q [$];
    grid_req_t      drv_item;
    int unsigned    send_gap     = 0;
    int unsigned    take_stall   = 0;
    bit             send_idle_en = 1'b1;
    bit             take_idle_en = 1'b1;
    int unsigned    mismatches   = 0;
    int unsigned    resp_count   = 0;
    int unsigned    quiet_cycles = 0;

    // grid sizes per phase; 0 and values above the maximum exercise clamping
    int unsigned plan_w [N_FIXED] = '{0, 1, 2, 1, 2, 3, 127, 65, 3, 5, 64, 7};
    int unsigned plan_h [N_FIXED] = '{0, 1, 2, 5, 3, 3, 127, 3, 100, 8, 64, 6};

    life_grid_step_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // effective grid dimension from a raw register value
    function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] raw, input int maxv);
        if (raw == 0) return 1;
        if (raw > maxv) return maxv;
        return raw;
    endfunction

    // one generation over the live plane into the other plane, torus wrap
    function automatic void advance_generation();
        int unsigned w, h, nbrs, nr, nc;
        bit src, dst, nxt;
        w = clamp_dim(width_reg, GRID_MAX_W);
        h = clamp_dim(height_reg, GRID_MAX_H);
        src = live_plane;
        dst = ~live_plane;
        for (int r = 0; r < GRID_MAX_H; r++) begin
            for (int c = 0; c < GRID_MAX_W; c++) begin
                nxt = 1'b0;
                if (r < h && c < w) begin
                    nbrs = 0;
                    // tiny grids count coinciding neighbor positions separately
                    for (int dr = 0; dr < 3; dr++) begin
                        for (int dc = 0; dc < 3; dc++) begin
                            if (!(dr == 1 && dc == 1)) begin
                                nr = (r + h + dr - 1) % h;
                                nc = (c + w + dc - 1) % w;
                                nbrs += grid_bits[src][nr][nc];
                            end
                        end
                    end
                    if (nbrs == NBR_BIRTH) nxt = 1'b1;
                    else if (nbrs == NBR_KEEP) nxt = grid_bits[src][r][c];
                end
                grid_bits[dst][r][c] = nxt;
            end
        end
        live_plane = dst;
    endfunction

    // update the grid for one accepted item and return its result
    function automatic grid_resp_t apply_request(input grid_req_t it);
        grid_resp_t res;
        int unsigned w, h;
        res = '0;
        w = clamp_dim(width_reg, GRID_MAX_W);
        h = clamp_dim(height_reg, GRID_MAX_H);
        case (it.req)
            REQ_WRITE: begin
                if (it.col < w && it.row < h) grid_bits[live_plane][it.row][it.col] = (it.val != 0);
            end
            REQ_READ: begin
                if (it.col < w && it.row < h) res.read_value = grid_bits[live_plane][it.row][it.col];
            end
            REQ_STEP: begin
                advance_generation();
                res.step_done = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void note_error(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch at result %0d: %s", resp_count, msg);
    endfunction

    // compare one result item with the oldest expectation
    function automatic void check_response(input logic [M_DATA_W-1:0] data);
        grid_resp_t want;
        if (expected_resp_q.size() == 0) begin
            note_error($sformatf("unexpected item tdata=%h", data));
            return;
        end
        want = expected_resp_q.pop_front();
        if (data[0] !== want.read_value)
            note_error($sformatf("read_value exp %b got %b", want.read_value, data[0]));
        if (data[1] !== want.step_done)
            note_error($sformatf("step_done exp %b got %b", want.step_done, data[1]));
        if (data[M_DATA_W-1:2] !== '0)
            note_error($sformatf("pad bits exp 0 got %h", data[M_DATA_W-1:2]));
    endfunction

    // request driver: one item in flight, gaps between items
    always @(posedge i_clk) begin
        logic nxt_valid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            nxt_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_resp_q.push_back(apply_request(drv_item));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_q.size() > 0) begin
                    drv_item = request_q.pop_front();
                    s_axis_tdata <= {{(S_DATA_W-VAL_W-ROW_W-COL_W){1'b0}},
                                     drv_item.val, drv_item.row, drv_item.col};
                    s_axis_tuser <= drv_item.req;
                    nxt_valid = 1'b1;
                    send_gap = send_idle_en ? pick_gap() : 0;
                end
            end
            s_axis_tvalid <= nxt_valid;
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_response(m_axis_tdata);
                resp_count++;
            end
            if (take_stall > 0) begin
                take_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                take_stall = take_idle_en ? pick_gap() : 0;
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_GRID_WIDTH) width_reg = val;
        else if (idx == CFG_GRID_HEIGHT) height_reg = val;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_item(input logic [REQ_W-1:0] req, input int unsigned col,
                              input int unsigned row, input int unsigned val);
        grid_req_t it;
        it.req = req;
        it.col = COL_W'(col);
        it.row = ROW_W'(row);
        it.val = VAL_W'(val);
        request_q.push_back(it);
    endtask

    // hold off until every queued item is accepted and answered
    task automatic wait_idle();
        while (request_q.size() != 0 || s_axis_tvalid || expected_resp_q.size() != 0)
            @(posedge i_clk);
    endtask

    // random items: mostly in-area writes and reads with some generations, plus noise
    task automatic queue_random_items(input int unsigned count);
        int unsigned w, h, pick, step_odds;
        grid_req_t it;
        w = clamp_dim(width_reg, GRID_MAX_W);
        h = clamp_dim(height_reg, GRID_MAX_H);
        step_odds = (w * h > 256) ? 3 : 14;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            it.col = COL_W'($urandom_range(0, w - 1));
            it.row = ROW_W'($urandom_range(0, h - 1));
            it.val = $urandom_range(0, 1) ? VAL_W'($urandom_range(1, 255)) : '0;
            if (pick < 45) begin
                it.req = REQ_WRITE;
            end else if (pick < 70) begin
                it.req = REQ_READ;
            end else if (pick < 70 + step_odds) begin
                it.req = REQ_STEP;
            end else begin
                it.req = REQ_W'($urandom_range(0, 3));
                it.col = COL_W'($urandom);
                it.row = ROW_W'($urandom);
                it.val = VAL_W'($urandom);
            end
            request_q.push_back(it);
        end
    endtask

    initial begin
        int unsigned w_set, h_set;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset state, then a blinker on the bottom row wrapping across the columns
        queue_item(REQ_READ,  0,  0, 8'h00);
        queue_item(REQ_READ,  63, 63, 8'h00);
        queue_item(REQ_WRITE, 63, 63, 8'hFF);
        queue_item(REQ_WRITE, 0,  63, 8'h01);
        queue_item(REQ_WRITE, 1,  63, 8'h80);
        queue_item(REQ_WRITE, 20, 20, 8'hAA);
        queue_item(REQ_READ,  20, 20, 8'h00);
        queue_item(REQ_WRITE, 20, 20, 8'h00);
        queue_item(REQ_READ,  20, 20, 8'h00);
        queue_item(REQ_READ,  63, 63, 8'h00);
        queue_item(REQ_UNUSED, 63, 63, 8'hFF);
        queue_item(REQ_READ,  0,  63, 8'h00);
        // blinker turns vertical at column 0, wrapping across the rows
        queue_item(REQ_STEP,  0,  0, 8'h00);
        queue_item(REQ_READ,  0,  62, 8'h00);
        queue_item(REQ_READ,  0,  63, 8'h00);
        queue_item(REQ_READ,  0,  0, 8'h00);
        queue_item(REQ_READ,  63, 63, 8'h00);
        queue_item(REQ_READ,  1,  63, 8'h00);
        queue_item(REQ_STEP,  0,  0, 8'h00);
        queue_item(REQ_READ,  1,  63, 8'h00);
        queue_item(REQ_READ,  0,  0, 8'h00);
        wait_idle();

        // phases over a range of grid sizes, registers written only while idle
        for (int p = 0; p < N_PHASES; p++) begin
            if (p < N_FIXED) begin
                w_set = plan_w[p];
                h_set = plan_h[p];
            end else begin
                w_set = $urandom_range(1, 12);
                h_set = $urandom_range(1, 12);
            end
            write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(w_set));
            write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(h_set));
            if (p == 3) write_reg(CFG_UNUSED_IDX, 7'h7F);
            send_idle_en = ($urandom_range(0, 3) != 0);
            take_idle_en = ($urandom_range(0, 3) != 0);
            queue_random_items(9);
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_resp_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
